[rtl/particle_contact_resolver_unit_defines.svh]
// Assertion macros shared by the contact resolver RTL.
`ifndef PARTICLE_CONTACT_RESOLVER_UNIT_DEFINES_SVH
`define PARTICLE_CONTACT_RESOLVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PCR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("contact resolver check failed");
`define PCR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("contact resolver check failed");
`else
`define PCR_ASSERT(lbl, prop)
`define PCR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/pcr_pkg.sv]
// Shared constants and types of the particle contact resolver.
package pcr_pkg;
	localparam int NORM_W    = 16;
	localparam int IM_W      = 16;
	localparam int R_W       = 9;
	localparam int PEN_W     = 16;
	localparam int FD_W      = 16;
	localparam int TOT_W     = IM_W + 1;
	localparam int TSHIFT    = 14;
	localparam int DV_SHIFT  = 14;
	localparam int VSHIFT    = 22;
	localparam int PSHIFT    = 28;
	localparam int ACC_SHIFT = 16;
	localparam int RST_SHIFT = 8;
	localparam int PIM_W     = PEN_W - 1 + IM_W;
	localparam int TQ_W      = PEN_W - 1 + TSHIFT;
	localparam int NLANES    = 4;
	localparam logic [FD_W-1:0] FD_RESET = 16'd1092;

	typedef logic [TOT_W-1:0] total_t;

	typedef enum int {
		LANE_VA = 0,
		LANE_VB = 1,
		LANE_PA = 2,
		LANE_PB = 3
	} lane_t;

	typedef enum int {
		UB_VCHG = 0,
		UB_PCHG = 1
	} ubit_t;
endpackage

[rtl/pcr_div.sv]
// Pipelined restoring divider: four lanes sharing one divisor, one quotient bit per stage.
module pcr_div #(
	parameter int QW     = 31,
	parameter int SIDE_W = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  pcr_pkg::total_t           in_tot,
	input  logic [QW+pcr_pkg::TOT_W-1:0] in_num [pcr_pkg::NLANES],
	input  logic [SIDE_W-1:0]         in_side,
	output logic                      out_vld,
	output logic [QW-1:0]             out_quo [pcr_pkg::NLANES],
	output logic [SIDE_W-1:0]         out_side
);
	import pcr_pkg::*;

	logic [TOT_W-1:0]  rem_s  [QW][NLANES];
	logic [QW-1:0]     quo_s  [QW][NLANES];
	logic              vld_s  [QW];
	total_t            tot_s  [QW];
	logic [SIDE_W-1:0] side_s [QW];

	// The top part of each dividend is below the divisor, so QW steps give the quotient.
	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [TOT_W-1:0]  rp [NLANES];
		logic [QW-1:0]     qp [NLANES];
		total_t            tp;
		logic [SIDE_W-1:0] sp;
		logic              vp;

		always_comb begin
			for (int l = 0; l < NLANES; l++) begin
				if (k == 0) begin
					rp[l] = in_num[l][QW +: TOT_W];
					qp[l] = in_num[l][QW-1:0];
				end else begin
					rp[l] = rem_s[(k == 0) ? 0 : k-1][l];
					qp[l] = quo_s[(k == 0) ? 0 : k-1][l];
				end
			end
			if (k == 0) begin
				tp = in_tot;
				sp = in_side;
				vp = in_vld;
			end else begin
				tp = tot_s[(k == 0) ? 0 : k-1];
				sp = side_s[(k == 0) ? 0 : k-1];
				vp = vld_s[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < NLANES; l++) begin
					logic [TOT_W:0] trial;
					logic [TOT_W:0] diff;
					trial = {rp[l], qp[l][QW-1]};
					diff  = trial - {1'b0, tp};
					if (trial >= {1'b0, tp}) begin
						rem_s[k][l] <= diff[TOT_W-1:0];
						quo_s[k][l] <= {qp[l][QW-2:0], 1'b1};
					end else begin
						rem_s[k][l] <= trial[TOT_W-1:0];
						quo_s[k][l] <= {qp[l][QW-2:0], 1'b0};
					end
				end
				tot_s[k]  <= tp;
				side_s[k] <= sp;
			end
		end
	end

	assign out_vld  = vld_s[QW-1];
	assign out_side = side_s[QW-1];
	always_comb begin
		for (int l = 0; l < NLANES; l++) begin
			out_quo[l] = quo_s[QW-1][l];
		end
	end
endmodule

[rtl/particle_contact_resolver_unit.sv]
// The pipeline has six arithmetic stages, one divider stage per quotient bit and two more stages,
// with QW = max(COMP_BITS+15, 29) quotient bits. Throughput: one contact per cycle while the output
// is not stalled; the long-division pipeline sets the depth, not the rate.
// A stalled output freezes the whole pipeline; s_axis_tready follows the output register.
// Reset clears all valid bits and loads frame_duration with 1092; payload registers are not reset.
`include "particle_contact_resolver_unit_defines.svh"
module particle_contact_resolver_unit #(
	parameter int COMP_BITS = 16,
	localparam int VW = 3 * COMP_BITS,
	localparam int IN_W = ((3 * pcr_pkg::NORM_W + 6 * VW + 2 * pcr_pkg::IM_W + pcr_pkg::R_W
		+ pcr_pkg::PEN_W + 7) / 8) * 8,
	localparam int OUT_W = ((4 * VW + 7) / 8) * 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [pcr_pkg::FD_W-1:0] cfg_data,          // frame_duration
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// normal, vel_a, vel_b, acc_a, acc_b, pos_a, pos_b, inv_mass_a, inv_mass_b,
	// restitution, penetration
	input  logic [IN_W-1:0]         s_axis_tdata,
	input  logic [0:0]              s_axis_tuser,      // has_b
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [OUT_W-1:0]        m_axis_tdata,      // new_vel_a, new_vel_b, new_pos_a, new_pos_b
	output logic [1:0]              m_axis_tuser       // velocity_changed, position_changed
);
	import pcr_pkg::*;

	localparam int CW      = COMP_BITS;
	localparam int RV_W    = CW + 1;
	localparam int PR_W    = CW + 17;
	localparam int SEP_W   = CW + 19;
	localparam int FDP_W   = SEP_W + FD_W + 1;
	localparam int NSR_W   = SEP_W + R_W;
	localparam int RACC_W  = SEP_W + R_W + 1;
	localparam int NS_W    = SEP_W + R_W + 2;
	localparam int DEL_W   = SEP_W + R_W + 1;
	localparam int DV_W    = DEL_W - DV_SHIFT;
	localparam int QW      = (DV_W > TQ_W) ? DV_W : TQ_W;
	localparam int NUM_W   = QW + TOT_W;
	localparam int MP_W    = QW + 1 + NORM_W;
	localparam int ADD_W   = MP_W + 1;
	localparam int BASE_W  = 3 * NORM_W + 4 * VW + 1;
	localparam int SIDE_W  = BASE_W + 2;
	localparam int SD_VA   = 3 * NORM_W;
	localparam int SD_VB   = SD_VA + VW;
	localparam int SD_PA   = SD_VB + VW;
	localparam int SD_PB   = SD_PA + VW;
	localparam int SD_HB   = SD_PB + VW;
	localparam int SD_VC   = BASE_W;
	localparam int SD_PC   = BASE_W + 1;
	localparam int OFF_VA  = 3 * NORM_W;
	localparam int OFF_VB  = OFF_VA + VW;
	localparam int OFF_AA  = OFF_VB + VW;
	localparam int OFF_AB  = OFF_AA + VW;
	localparam int OFF_PA  = OFF_AB + VW;
	localparam int OFF_PB  = OFF_PA + VW;
	localparam int OFF_IMA = OFF_PB + VW;
	localparam int OFF_IMB = OFF_IMA + IM_W;
	localparam int OFF_R   = OFF_IMB + IM_W;
	localparam int OFF_PEN = OFF_R + R_W;
	localparam logic signed [ADD_W-1:0] VRND = ADD_W'(1) <<< (VSHIFT - 1);
	localparam logic signed [ADD_W-1:0] PRND = ADD_W'(1) <<< (PSHIFT - 1);
	localparam logic signed [ADD_W-1:0] CMAX = (ADD_W'(1) <<< (CW - 1)) - ADD_W'(1);
	localparam logic signed [ADD_W-1:0] CMIN = -(ADD_W'(1) <<< (CW - 1));

	function automatic logic [CW-1:0] sat_comp(input logic signed [ADD_W-1:0] v);
		logic [CW-1:0] r;
		if (v > CMAX) begin
			r = CMAX[CW-1:0];
		end else if (v < CMIN) begin
			r = CMIN[CW-1:0];
		end else begin
			r = v[CW-1:0];
		end
		return r;
	endfunction

	logic            en;
	logic [FD_W-1:0] fd_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fd_q <= FD_RESET;
		end else if (cfg_valid) begin
			fd_q <= cfg_data;
		end
	end

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// Stage 1: relative velocity and acceleration products with the normal.
	logic signed [PR_W-1:0]  rvn_c [3];
	logic signed [PR_W-1:0]  ran_c [3];
	logic                    hb_c;
	logic [IM_W-1:0]         imb_c;
	logic signed [PEN_W-1:0] pen_c;
	logic [PIM_W-1:0]        pima_c;
	logic [PIM_W-1:0]        pimb_c;

	always_comb begin
		logic signed [NORM_W-1:0] n;
		logic signed [CW-1:0]     va, vb, aa, ab;
		logic signed [RV_W-1:0]   rv, ra;
		hb_c  = s_axis_tuser[0];
		imb_c = hb_c ? s_axis_tdata[OFF_IMB +: IM_W] : '0;
		pen_c = $signed(s_axis_tdata[OFF_PEN +: PEN_W]);
		for (int i = 0; i < 3; i++) begin
			n  = $signed(s_axis_tdata[i*NORM_W +: NORM_W]);
			va = $signed(s_axis_tdata[OFF_VA + i*CW +: CW]);
			vb = hb_c ? $signed(s_axis_tdata[OFF_VB + i*CW +: CW]) : '0;
			aa = $signed(s_axis_tdata[OFF_AA + i*CW +: CW]);
			ab = hb_c ? $signed(s_axis_tdata[OFF_AB + i*CW +: CW]) : '0;
			rv = va - vb;
			ra = aa - ab;
			rvn_c[i] = rv * n;
			ran_c[i] = ra * n;
		end
		pima_c = pen_c[PEN_W-2:0] * s_axis_tdata[OFF_IMA +: IM_W];
		pimb_c = pen_c[PEN_W-2:0] * imb_c;
	end

	logic                   vld_s1;
	logic signed [PR_W-1:0] rvn_s1 [3];
	logic signed [PR_W-1:0] ran_s1 [3];
	logic [IM_W-1:0]        ima_s1, imb_s1;
	logic [R_W-1:0]         r_s1;
	logic                   penpos_s1;
	logic [PIM_W-1:0]       pima_s1, pimb_s1;
	logic [BASE_W-1:0]      base_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rvn_s1    <= rvn_c;
			ran_s1    <= ran_c;
			ima_s1    <= s_axis_tdata[OFF_IMA +: IM_W];
			imb_s1    <= imb_c;
			r_s1      <= s_axis_tdata[OFF_R +: R_W];
			penpos_s1 <= (pen_c > 0);
			pima_s1   <= pima_c;
			pimb_s1   <= pimb_c;
			base_s1   <= {hb_c, s_axis_tdata[OFF_PB +: VW], s_axis_tdata[OFF_PA +: VW],
				s_axis_tdata[OFF_VB +: VW], s_axis_tdata[OFF_VA +: VW],
				s_axis_tdata[0 +: 3*NORM_W]};
		end
	end

	// Stage 2: dot products, total inverse mass and the two run conditions.
	logic signed [SEP_W-1:0] sep_c, accs_c;
	total_t                  tot_c;

	always_comb begin
		sep_c  = rvn_s1[0] + rvn_s1[1] + rvn_s1[2];
		accs_c = ran_s1[0] + ran_s1[1] + ran_s1[2];
		tot_c  = ima_s1 + imb_s1;
	end

	logic                    vld_s2;
	logic signed [SEP_W-1:0] sep_s2, accs_s2;
	total_t                  tot_s2;
	logic                    vchg_s2, pchg_s2;
	logic [IM_W-1:0]         ima_s2, imb_s2;
	logic [R_W-1:0]          r_s2;
	logic [PIM_W-1:0]        pima_s2, pimb_s2;
	logic [BASE_W-1:0]       base_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sep_s2  <= sep_c;
			accs_s2 <= accs_c;
			tot_s2  <= tot_c;
			vchg_s2 <= (sep_c <= 0) && (tot_c != '0);
			pchg_s2 <= penpos_s1 && (tot_c != '0);
			ima_s2  <= ima_s1;
			imb_s2  <= imb_s1;
			r_s2    <= r_s1;
			pima_s2 <= pima_s1;
			pimb_s2 <= pimb_s1;
			base_s2 <= base_s1;
		end
	end

	// Stage 3: acceleration term times the frame time, restitution times the closing speed.
	logic [SEP_W-1:0] negsep_c;
	assign negsep_c = -sep_s2;

	logic                    vld_s3;
	logic signed [SEP_W-1:0] sep_s3;
	logic signed [FDP_W-1:0] fdp_s3;
	logic [SEP_W-1:0]        negsep_s3;
	logic [NSR_W-1:0]        nsr_s3;
	total_t                  tot_s3;
	logic                    vchg_s3, pchg_s3;
	logic [IM_W-1:0]         ima_s3, imb_s3;
	logic [R_W-1:0]          r_s3;
	logic [PIM_W-1:0]        pima_s3, pimb_s3;
	logic [BASE_W-1:0]       base_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sep_s3    <= sep_s2;
			fdp_s3    <= accs_s2 * $signed({1'b0, fd_q});
			negsep_s3 <= negsep_c;
			nsr_s3    <= negsep_c * r_s2;
			tot_s3    <= tot_s2;
			vchg_s3   <= vchg_s2;
			pchg_s3   <= pchg_s2;
			ima_s3    <= ima_s2;
			imb_s3    <= imb_s2;
			r_s3      <= r_s2;
			pima_s3   <= pima_s2;
			pimb_s3   <= pimb_s2;
			base_s3   <= base_s2;
		end
	end

	// Stage 4: velocity gained this frame, scaled by restitution.
	logic signed [SEP_W-1:0] accsep_c;
	assign accsep_c = $signed(fdp_s3[ACC_SHIFT +: SEP_W]);

	logic                     vld_s4;
	logic signed [RACC_W-1:0] racc_s4;
	logic                     accneg_s4;
	logic [SEP_W-1:0]         negsep_s4;
	logic [NSR_W-1:0]         nsr_s4;
	total_t                   tot_s4;
	logic                     vchg_s4, pchg_s4;
	logic [IM_W-1:0]          ima_s4, imb_s4;
	logic [PIM_W-1:0]         pima_s4, pimb_s4;
	logic [BASE_W-1:0]        base_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			racc_s4   <= accsep_c * $signed({1'b0, r_s3});
			accneg_s4 <= accsep_c[SEP_W-1];
			negsep_s4 <= negsep_s3;
			nsr_s4    <= nsr_s3;
			tot_s4    <= tot_s3;
			vchg_s4   <= vchg_s3;
			pchg_s4   <= pchg_s3;
			ima_s4    <= ima_s3;
			imb_s4    <= imb_s3;
			pima_s4   <= pima_s3;
			pimb_s4   <= pimb_s3;
			base_s4   <= base_s3;
		end
	end

	// Stage 5: new separating speed, clamped at zero, and the velocity change.
	logic signed [RACC_W-1:0] racc_m;
	logic signed [NS_W-1:0]   ns_c;
	logic [DEL_W-1:0]         nscl_c;
	logic [DEL_W-1:0]         delta_c;

	always_comb begin
		racc_m  = accneg_s4 ? racc_s4 : '0;
		ns_c    = $signed({1'b0, nsr_s4}) + racc_m;
		nscl_c  = ns_c[NS_W-1] ? '0 : ns_c[DEL_W-1:0];
		delta_c = nscl_c + DEL_W'({negsep_s4, {RST_SHIFT{1'b0}}});
	end

	logic              vld_s5;
	logic [DV_W-1:0]   dv_s5;
	total_t            tot_s5;
	logic              vchg_s5, pchg_s5;
	logic [IM_W-1:0]   ima_s5, imb_s5;
	logic [PIM_W-1:0]  pima_s5, pimb_s5;
	logic [BASE_W-1:0] base_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s5   <= delta_c[DEL_W-1:DV_SHIFT];
			tot_s5  <= tot_s4;
			vchg_s5 <= vchg_s4;
			pchg_s5 <= pchg_s4;
			ima_s5  <= ima_s4;
			imb_s5  <= imb_s4;
			pima_s5 <= pima_s4;
			pimb_s5 <= pimb_s4;
			base_s5 <= base_s4;
		end
	end

	// Stage 6: dividends for the four shares.
	logic              vld_s6;
	logic [NUM_W-1:0]  num_s6 [NLANES];
	total_t            tot_s6;
	logic [SIDE_W-1:0] side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s6[LANE_VA] <= NUM_W'(dv_s5 * ima_s5);
			num_s6[LANE_VB] <= NUM_W'(dv_s5 * imb_s5);
			num_s6[LANE_PA] <= NUM_W'({pima_s5, {TSHIFT{1'b0}}});
			num_s6[LANE_PB] <= NUM_W'({pimb_s5, {TSHIFT{1'b0}}});
			tot_s6          <= tot_s5;
			side_s6         <= {pchg_s5, vchg_s5, base_s5};
		end
	end

	logic              dvld;
	logic [QW-1:0]     quo [NLANES];
	logic [SIDE_W-1:0] dside;

	pcr_div #(
		.QW     (QW),
		.SIDE_W (SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s6),
		.in_tot   (tot_s6),
		.in_num   (num_s6),
		.in_side  (side_s6),
		.out_vld  (dvld),
		.out_quo  (quo),
		.out_side (dside)
	);

	// Stage 7: shares projected onto the normal.
	logic                   vld_s7;
	logic signed [MP_W-1:0] prod_s7 [NLANES][3];
	logic [SIDE_W-1:0]      side_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= dvld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NLANES; l++) begin
				for (int i = 0; i < 3; i++) begin
					prod_s7[l][i] <= $signed({1'b0, quo[l]})
						* $signed(dside[i*NORM_W +: NORM_W]);
				end
			end
			side_s7 <= dside;
		end
	end

	// Stage 8: round, apply, saturate, and select the pass-through cases.
	logic [VW-1:0] nva_c, nvb_c, npa_c, npb_c;

	always_comb begin
		logic signed [ADD_W-1:0] rva, rvb, rpa, rpb;
		logic signed [ADD_W-1:0] va, vb, pa, pb;
		logic                    hb, vc, pc;
		hb = side_s7[SD_HB];
		vc = side_s7[SD_VC];
		pc = side_s7[SD_PC];
		for (int i = 0; i < 3; i++) begin
			va  = $signed(side_s7[SD_VA + i*CW +: CW]);
			vb  = $signed(side_s7[SD_VB + i*CW +: CW]);
			pa  = $signed(side_s7[SD_PA + i*CW +: CW]);
			pb  = $signed(side_s7[SD_PB + i*CW +: CW]);
			rva = (ADD_W'(prod_s7[LANE_VA][i]) + VRND) >>> VSHIFT;
			rvb = (ADD_W'(prod_s7[LANE_VB][i]) + VRND) >>> VSHIFT;
			rpa = (ADD_W'(prod_s7[LANE_PA][i]) + PRND) >>> PSHIFT;
			rpb = (ADD_W'(prod_s7[LANE_PB][i]) + PRND) >>> PSHIFT;
			nva_c[i*CW +: CW] = vc ? sat_comp(va + rva) : va[CW-1:0];
			nvb_c[i*CW +: CW] = (vc && hb) ? sat_comp(vb - rvb) : vb[CW-1:0];
			npa_c[i*CW +: CW] = pc ? sat_comp(pa + rpa) : pa[CW-1:0];
			npb_c[i*CW +: CW] = (pc && hb) ? sat_comp(pb - rpb) : pb[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata          <= OUT_W'({npb_c, npa_c, nvb_c, nva_c});
			m_axis_tuser[UB_VCHG] <= side_s7[SD_VC];
			m_axis_tuser[UB_PCHG] <= side_s7[SD_PC];
		end
	end

	// An immovable pair must never raise either flag.
	`PCR_ASSERT(a_zero_total_no_flags, (vld_s2 && tot_s2 == '0) |-> (!vchg_s2 && !pchg_s2))
	// The impulse flag only travels with a closing or resting contact.
	`PCR_ASSERT(a_vchg_closing, (vld_s3 && vchg_s3) |-> (sep_s3 <= 0))
	// Without a negative acceleration term the new separating speed cannot go below zero.
	`PCR_ASSERT(a_ns_nonneg, (vld_s4 && vchg_s4 && !accneg_s4) |-> !ns_c[NS_W-1])
	// A held pipeline keeps the divider feed in place.
	`PCR_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_s6) && $stable(tot_s6))
endmodule
